@@ rtl/core/fifo_priority_queue_max_tracking_defines.svh @@
// Assertion macros for the priority queue block
`ifndef FIFO_PRIORITY_QUEUE_MAX_TRACKING_DEFINES_SVH
`define FIFO_PRIORITY_QUEUE_MAX_TRACKING_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define FPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define FPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fpq_pkg.sv @@
// Types and constants for the priority queue block
package fpq_pkg;

  localparam int HANDLE_W = 8;
  localparam int PRIO_W   = 4;
  localparam int STATUS_W = 2;
  localparam int OCOUNT_W = 5;

  localparam logic [PRIO_W-1:0] MAX_PRIO = 4'd9;

  // Operation codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } fpq_state_t;

endpackage

@@ rtl/core/fifo_priority_queue_max_tracking.sv @@
// Priority queue of packet handles, oldest first within each priority level
//
// Usage: drive in_mode / in_entry_handle / in_entry_priority with start high;
// the transaction is taken on a clock edge where busy is low. Each transaction
// gives one result, shown for a single cycle with out_strobe high; the
// receiver cannot stall it.
// A push (or any rejected operation) completes in the accept cycle: its result
// appears in the next cycle and busy stays low, so one may follow every cycle.
// A pop on a non-empty queue walks the slot memory once, one slot per cycle,
// through a single 4-bit compare unit: it finds the oldest entry at the
// tracked top priority, moves the later entries down by one slot and rebuilds
// the top priority on the way. Busy is high while the walk runs and the result
// strobes in the cycle after its last slot, so no new transaction is taken
// before then; the one-read, one-write slot memory sets the pace of the walk.
// Pushed priorities above nine are saturated to nine.
// Reset (rst_n low, synchronous) empties the queue and sets the top priority
// to zero; slot contents are not cleared, only held slots are ever used.
module fifo_priority_queue_max_tracking #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_mode,
  input  logic [fpq_pkg::HANDLE_W-1:0]   in_entry_handle,
  input  logic [fpq_pkg::PRIO_W-1:0]     in_entry_priority,
  output logic                           out_strobe,
  output logic [fpq_pkg::HANDLE_W-1:0]   out_popped_handle,
  output logic [fpq_pkg::PRIO_W-1:0]     out_popped_priority,
  output logic [fpq_pkg::STATUS_W-1:0]   out_status,
  output logic [fpq_pkg::OCOUNT_W-1:0]   out_queue_count,
  output logic [fpq_pkg::PRIO_W-1:0]     out_top_priority
);
  import fpq_pkg::*;

  `include "fifo_priority_queue_max_tracking_defines.svh"

  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // Sequencer and queue state
  fpq_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [PRIO_W-1:0]    high_r, high_nxt;
  logic [CNT_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 found_r, found_nxt;
  logic [PRIO_W-1:0]    max_r, max_nxt;
  entry_t               got_r, got_nxt;

  // Result registers
  logic                 strobe_r, strobe_nxt;
  logic [HANDLE_W-1:0]  o_handle_r, o_handle_nxt;
  logic [PRIO_W-1:0]    o_prio_r, o_prio_nxt;
  logic [STATUS_W-1:0]  o_status_r, o_status_nxt;
  logic [OCOUNT_W-1:0]  o_count_r, o_count_nxt;
  logic [PRIO_W-1:0]    o_top_r, o_top_nxt;

  // Slot memory: one write and one registered read per cycle
  entry_t               slot_mem [QUEUE_DEPTH];
  entry_t               rd_data_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  entry_t               wr_data;

  // Compare unit signals
  logic [PRIO_W-1:0]    push_prio;
  logic                 is_last;
  logic                 take;
  logic [PRIO_W-1:0]    max_upd;
  entry_t               got_cur;
  logic [CNT_W-1:0]     shift_idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= slot_mem[rd_addr];
  end

  // Shared compare unit: saturation, match and running maximum
  assign push_prio = (in_entry_priority > MAX_PRIO) ? MAX_PRIO : in_entry_priority;
  assign is_last   = (scan_idx_r == count_r);
  assign take      = !found_r && ((rd_data_r.prio == high_r) || is_last);
  assign max_upd   = (!take && (rd_data_r.prio > max_r)) ? rd_data_r.prio : max_r;
  assign got_cur   = take ? rd_data_r : got_r;
  assign shift_idx = scan_idx_r - CNT_W'(2);

  // Next state and outputs
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    high_nxt     = high_r;
    scan_idx_nxt = scan_idx_r;
    found_nxt    = found_r;
    max_nxt      = max_r;
    got_nxt      = got_r;
    strobe_nxt   = 1'b0;
    o_handle_nxt = o_handle_r;
    o_prio_nxt   = o_prio_r;
    o_status_nxt = o_status_r;
    o_count_nxt  = o_count_r;
    o_top_nxt    = o_top_r;
    wr_en        = 1'b0;
    wr_addr      = count_r[ADDR_W-1:0];
    wr_data      = rd_data_r;
    rd_addr      = scan_idx_r[ADDR_W-1:0];
    busy         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        rd_addr = '0;
        if (start) begin
          o_handle_nxt = '0;
          o_prio_nxt   = '0;
          o_status_nxt = STATUS_OK;
          strobe_nxt   = 1'b1;
          if (in_mode == MODE_PUSH) begin
            if (count_r >= DEPTH_C) begin
              o_status_nxt = STATUS_PUSH_FULL;
            end else begin
              wr_en          = 1'b1;
              wr_data.handle = in_entry_handle;
              wr_data.prio   = push_prio;
              count_nxt      = count_r + CNT_W'(1);
              if (push_prio > high_r) begin
                high_nxt = push_prio;
              end
            end
          end else if (count_r == '0) begin
            o_status_nxt = STATUS_POP_EMPTY;
          end else begin
            // slot 0 is being read this cycle
            strobe_nxt   = 1'b0;
            state_nxt    = ST_SCAN;
            scan_idx_nxt = CNT_W'(1);
            found_nxt    = 1'b0;
            max_nxt      = '0;
          end
          o_count_nxt = OCOUNT_W'(count_nxt);
          o_top_nxt   = high_nxt;
        end
      end
      ST_SCAN: begin
        busy         = 1'b1;
        max_nxt      = max_upd;
        got_nxt      = got_cur;
        scan_idx_nxt = scan_idx_r + CNT_W'(1);
        if (take) begin
          found_nxt = 1'b1;
        end
        // close the gap behind the removed entry
        if (found_r) begin
          wr_en   = 1'b1;
          wr_addr = shift_idx[ADDR_W-1:0];
          wr_data = rd_data_r;
        end
        if (is_last) begin
          state_nxt    = ST_IDLE;
          count_nxt    = count_r - CNT_W'(1);
          high_nxt     = max_upd;
          strobe_nxt   = 1'b1;
          o_handle_nxt = got_cur.handle;
          o_prio_nxt   = got_cur.prio;
          o_status_nxt = STATUS_OK;
          o_count_nxt  = OCOUNT_W'(count_nxt);
          o_top_nxt    = max_upd;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      high_r   <= '0;
      found_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      high_r   <= high_nxt;
      found_r  <= found_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    max_r      <= max_nxt;
    got_r      <= got_nxt;
    o_handle_r <= o_handle_nxt;
    o_prio_r   <= o_prio_nxt;
    o_status_r <= o_status_nxt;
    o_count_r  <= o_count_nxt;
    o_top_r    <= o_top_nxt;
  end

  assign out_strobe          = strobe_r;
  assign out_popped_handle   = o_handle_r;
  assign out_popped_priority = o_prio_r;
  assign out_status          = o_status_r;
  assign out_queue_count     = o_count_r;
  assign out_top_priority    = o_top_r;

  // Checks
  `FPQ_ASSERT_NEXT(a_accept_gives_work, start && !busy, out_strobe || busy, "transaction dropped")
  `FPQ_ASSERT_NOW(a_empty_top_zero, count_r == '0, high_r == '0, "empty queue with nonzero top")
  `FPQ_ASSERT_NOW(a_count_bound, state_r == ST_IDLE, count_r <= DEPTH_C, "count above depth")
  `FPQ_ASSERT_NOW(a_top_bound, out_strobe, out_top_priority <= MAX_PRIO, "top priority above nine")

endmodule

@@ tb/sv/fpq_order_check.sv @@
// Predicts priority queue results from observed transactions and compares them
`timescale 1ns / 1ps

module fpq_order_check
  import fpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic                in_mode,
  input  logic [HANDLE_W-1:0] in_entry_handle,
  input  logic [PRIO_W-1:0]   in_entry_priority,
  input  logic                out_strobe,
  input  logic [HANDLE_W-1:0] out_popped_handle,
  input  logic [PRIO_W-1:0]   out_popped_priority,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [OCOUNT_W-1:0] out_queue_count,
  input  logic [PRIO_W-1:0]   out_top_priority,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
    logic [STATUS_W-1:0] status;
    logic [OCOUNT_W-1:0] count;
    logic [PRIO_W-1:0]   top;
  } queue_result_t;

  // Shadow copy of the queue, oldest entry in slot 0
  entry_t            shadow_slots [QUEUE_DEPTH];
  int                shadow_held;
  logic [PRIO_W-1:0] shadow_top;

  queue_result_t results_due[$];
  queue_result_t oldest_due;
  int            mismatches;

  // Applies one operation to the shadow queue and returns its result
  function automatic queue_result_t apply_queue_op(logic mode, logic [HANDLE_W-1:0] handle,
                                                   logic [PRIO_W-1:0] prio);
    queue_result_t     res;
    logic [PRIO_W-1:0] level;
    int                pos;
    int                i;
    res   = '0;
    level = (prio > MAX_PRIO) ? MAX_PRIO : prio;
    if (mode == MODE_PUSH) begin
      if (shadow_held >= QUEUE_DEPTH) begin
        res.status = STATUS_PUSH_FULL;
      end else begin
        shadow_slots[shadow_held] = '{handle: handle, prio: level};
        shadow_held++;
        if (level > shadow_top) shadow_top = level;
      end
    end else if (shadow_held == 0) begin
      res.status = STATUS_POP_EMPTY;
    end else begin
      // oldest entry at the tracked top level, then close the gap
      pos = 0;
      while (pos + 1 < shadow_held && shadow_slots[pos].prio != shadow_top) pos++;
      res.handle = shadow_slots[pos].handle;
      res.prio   = shadow_slots[pos].prio;
      for (i = pos; i + 1 < shadow_held; i++) shadow_slots[i] = shadow_slots[i + 1];
      shadow_held--;
      shadow_top = '0;
      for (i = 0; i < shadow_held; i++)
        if (shadow_slots[i].prio > shadow_top) shadow_top = shadow_slots[i].prio;
    end
    res.status = res.status;
    res.count  = OCOUNT_W'(shadow_held);
    res.top    = shadow_top;
    return res;
  endfunction

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      mismatches++;
    end
  endtask

  // Results are compared before the same edge's transaction is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_held = 0;
      shadow_top  = '0;
      results_due.delete();
    end else begin
      if (out_strobe) begin
        if (results_due.size() == 0) begin
          $error("result strobed with no transaction outstanding");
          mismatches++;
        end else begin
          oldest_due = results_due.pop_front();
          check_field("popped_handle", int'(oldest_due.handle), int'(out_popped_handle));
          check_field("popped_priority", int'(oldest_due.prio), int'(out_popped_priority));
          check_field("status", int'(oldest_due.status), int'(out_status));
          check_field("queue_count", int'(oldest_due.count), int'(out_queue_count));
          check_field("top_priority", int'(oldest_due.top), int'(out_top_priority));
        end
      end
      if (start && !busy)
        results_due.push_back(apply_queue_op(in_mode, in_entry_handle, in_entry_priority));
    end
    pending    <= results_due.size();
    fail_count <= mismatches;
  end

endmodule

@@ tb/sv/testbench.sv @@
// Stimulus and verdict for the priority queue block
`timescale 1ns / 1ps

module testbench;
  import fpq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 400;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_mode;
  logic [HANDLE_W-1:0] in_entry_handle;
  logic [PRIO_W-1:0]   in_entry_priority;
  logic                out_strobe;
  logic [HANDLE_W-1:0] out_popped_handle;
  logic [PRIO_W-1:0]   out_popped_priority;
  logic [STATUS_W-1:0] out_status;
  logic [OCOUNT_W-1:0] out_queue_count;
  logic [PRIO_W-1:0]   out_top_priority;
  int                  fail_count;
  int                  pending;
  int                  cycle_count = 0;
  int                  sender_idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fifo_priority_queue_max_tracking #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_entry_handle    (in_entry_handle),
    .in_entry_priority  (in_entry_priority),
    .out_strobe         (out_strobe),
    .out_popped_handle  (out_popped_handle),
    .out_popped_priority(out_popped_priority),
    .out_status         (out_status),
    .out_queue_count    (out_queue_count),
    .out_top_priority   (out_top_priority)
  );

  fpq_order_check #(.QUEUE_DEPTH(QUEUE_DEPTH)) order_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_entry_handle    (in_entry_handle),
    .in_entry_priority  (in_entry_priority),
    .out_strobe         (out_strobe),
    .out_popped_handle  (out_popped_handle),
    .out_popped_priority(out_popped_priority),
    .out_status         (out_status),
    .out_queue_count    (out_queue_count),
    .out_top_priority   (out_top_priority),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL fifo_priority_queue_max_tracking");
      $finish;
    end
  end

  // One transaction, after a random gap; start stays high for a following one
  task automatic queue_op(input logic mode, input logic [HANDLE_W-1:0] handle,
                          input logic [PRIO_W-1:0] prio);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start             <= 1'b1;
    in_mode           <= mode;
    in_entry_handle   <= handle;
    in_entry_priority <= prio;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every outstanding result has come back
  task automatic wait_queue_settled();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly small priority sets so that equal levels queue up behind each other
  function automatic logic [PRIO_W-1:0] pick_priority();
    case ($urandom_range(0, 2))
      0:       return PRIO_W'($urandom_range(0, 15));
      1:       return PRIO_W'($urandom_range(0, 2));
      default: return PRIO_W'($urandom_range(5, 9));
    endcase
  endfunction

  // Bursts leaning to pushes, to pops or balanced, to sweep full and empty
  task automatic random_phase(input int items);
    int sent;
    int burst;
    int push_pct;
    int k;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(10, 40);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      for (k = 0; k < burst && sent < items; k++) begin
        queue_op(($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP,
                 HANDLE_W'($urandom_range(0, 255)), pick_priority());
        sent++;
      end
      if ($urandom_range(0, 19) == 0) wait_queue_settled();
    end
  endtask

  initial begin
    int i;
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_mode           <= MODE_PUSH;
    in_entry_handle   <= '0;
    in_entry_priority <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, extremes, saturation, fill to full, middle pops
    queue_op(MODE_POP, 8'hFF, 4'hF);
    queue_op(MODE_PUSH, 8'h00, 4'd0);
    queue_op(MODE_PUSH, 8'hFF, 4'd15);
    queue_op(MODE_PUSH, 8'h55, 4'd9);
    queue_op(MODE_PUSH, 8'hAA, 4'd10);
    queue_op(MODE_PUSH, 8'h0F, 4'd4);
    for (i = 0; i < 11; i++) queue_op(MODE_PUSH, HANDLE_W'(8'h10 + i), PRIO_W'(i % 5));
    queue_op(MODE_PUSH, 8'hF0, 4'd9);
    queue_op(MODE_POP, 8'h00, 4'd0);
    queue_op(MODE_POP, 8'h00, 4'd0);
    queue_op(MODE_POP, 8'h00, 4'd0);
    queue_op(MODE_POP, 8'h00, 4'd0);
    queue_op(MODE_POP, 8'h00, 4'd0);
    wait_queue_settled();

    // Random: sender gaps light, then heavy, then none
    sender_idle_pct = 14;
    random_phase(PHASE_ITEMS);
    wait_queue_settled();
    sender_idle_pct = 78;
    random_phase(PHASE_ITEMS);
    wait_queue_settled();
    sender_idle_pct = 0;
    random_phase(PHASE_ITEMS);
    wait_queue_settled();

    // Let a stray strobe show up before the verdict
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS fifo_priority_queue_max_tracking");
    end else begin
      $display("FAIL fifo_priority_queue_max_tracking");
    end
    $finish;
  end

endmodule
